FILE: hw/rtl/chbd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the center heatmap box decoder
// used by the front, queue, back and top level modules

package chbd_pkg;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int COORD_W     = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_RATIO_W      = 3'd1,
      CSR_RATIO_H      = 3'd2,
      CSR_IMAGE_SCALE  = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5,
      CSR_QUALITY_MODE = 3'd6,
      CSR_CLASS_MAP    = 3'd7
   } csr_idx_type;

   // one peak, as handed from the front to the back
   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic [15:0]               score;
      logic [15:0]               quality;
      logic                      quality_valid;
      logic [3:0]                label;
   } peak_type;

endpackage

FILE: hw/rtl/chbd_front.sv
`timescale 1ns / 1ps
// front: cell counters, peak test and corner forming in Q.9 grid units
// depends on chbd_pkg

module chbd_front
   import chbd_pkg::*;
#(
   parameter int GRID_W      = 128,
   parameter int GRID_H      = 128,
   parameter int NUM_CLASSES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [15:0]         heat_score,
   input  logic [15:0]         pooled_max,
   input  logic signed [20:0]  box_width,
   input  logic signed [20:0]  box_height,
   input  logic signed [20:0]  offset_x,
   input  logic signed [20:0]  offset_y,
   input  logic signed [16:0]  quality_score,
   input  logic                last_in_image,
   input  logic [15:0]         threshold,
   input  logic                quality_mode,
   input  logic [31:0]         class_map,
   output logic                push,
   output peak_type            peak,
   input  logic                full
);

   localparam int COL_W = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int ROW_W = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CLS_W-1:0] cls_ff, cls_in;
   logic             take;
   logic signed [COORD_W-1:0] cx, cy;
   logic [2:0]       cls3;

   assign in_ready = !full;
   assign take     = in_valid && in_ready;
   assign push     = take && (heat_score > threshold) && (heat_score == pooled_max);
   assign cls3     = 3'(cls_ff);

   always_comb begin
      cx = (COORD_W'(col_ff) <<< 9) + (COORD_W'(offset_x) <<< 1);
      cy = (COORD_W'(row_ff) <<< 9) + (COORD_W'(offset_y) <<< 1);
      peak.x0 = cx - COORD_W'(box_width);
      peak.y0 = cy - COORD_W'(box_height);
      peak.x1 = cx + COORD_W'(box_width);
      peak.y1 = cy + COORD_W'(box_height);
      peak.score = heat_score;
      if (quality_mode) begin
         peak.quality       = quality_score[16] ? 16'd0 : quality_score[15:0];
         peak.quality_valid = 1'b1;
         peak.label         = class_map[{cls3, 2'b00} +: 4];
      end else begin
         peak.quality       = 16'd0;
         peak.quality_valid = 1'b0;
         peak.label         = 4'(cls3);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cls_in = cls_ff;
      priority if (last_in_image) begin
         col_in = '0;
         row_in = '0;
         cls_in = '0;
      end else if (32'(col_ff) + 1 >= GRID_W) begin
         col_in = '0;
         if (32'(row_ff) + 1 >= GRID_H) begin
            row_in = '0;
            cls_in = (32'(cls_ff) + 1 >= NUM_CLASSES) ? '0 : cls_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cls_ff <= '0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cls_ff <= cls_in;
      end
   end

endmodule

FILE: hw/rtl/chbd_queue.sv
`timescale 1ns / 1ps
// short fifo of peaks between front and back
// depends on chbd_pkg

module chbd_queue
   import chbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  peak_type push_data,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output peak_type pop_data
);

   peak_type   mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign full      = cnt_ff == 3'd4;
   assign pop_valid = cnt_ff != 3'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

endmodule

FILE: hw/rtl/chbd_back.sv
`timescale 1ns / 1ps
// back: sequential corner scaling with a ratio multiplier and an image-scale multiplier, clamping, output register
// depends on chbd_pkg

module chbd_back
   import chbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_pop,
   input  peak_type           peak,
   input  logic [23:0]        ratio_w,
   input  logic [23:0]        ratio_h,
   input  logic [23:0]        image_scale,
   input  logic [13:0]        image_width,
   input  logic [13:0]        image_height,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [12:0]        top_left_x,
   output logic [12:0]        top_left_y,
   output logic signed [13:0] bottom_right_x,
   output logic signed [13:0] bottom_right_y,
   output logic [15:0]        peak_score,
   output logic [15:0]        quality_out,
   output logic               quality_valid,
   output logic [3:0]         label
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_GRID  = 4'b0010,
      ST_IMAGE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type  st_ff, st_in;
   logic [1:0] idx_ff;
   peak_type   pk_ff;
   logic [13:0] res_ff [4];
   logic        neg_ff;
   logic [55:0] gmag_ff;
   logic        gpos_big_ff;
   logic        ovalid_ff;

   logic signed [COORD_W-1:0] corner;
   logic [23:0] ratio;
   logic signed [14:0] lim;
   logic [31:0] cmag;
   logic [55:0] gprod;
   logic [46:0] smag_src;
   logic [70:0] sprod;
   logic [38:0] pix;
   logic [13:0] val;
   logic        is_br;
   logic        gpos_big;

   always_comb begin
      unique case (idx_ff)
         2'd0: corner = pk_ff.x0;
         2'd1: corner = pk_ff.y0;
         2'd2: corner = pk_ff.x1;
         default: corner = pk_ff.y1;
      endcase
   end

   assign is_br = idx_ff[1];
   assign ratio = idx_ff[0] ? ratio_h : ratio_w;
   assign lim   = idx_ff[0] ? (15'(image_height) - 15'sd1) : (15'(image_width) - 15'sd1);
   assign cmag  = corner[COORD_W-1] ? 32'(-corner) : 32'(corner);
   assign gprod = 56'(cmag) * 56'(ratio);
   // g > lim * 2^25 with g = +-gprod; lim is -1 only for a zero image size
   always_comb begin
      if (lim[14])
         gpos_big = !corner[COORD_W-1] || (gprod < 56'd33554432);
      else
         gpos_big = !corner[COORD_W-1] && (gprod > (56'(lim[13:0]) << 25));
   end

   assign smag_src = gmag_ff[55:9];
   assign sprod    = 71'(smag_src) * 71'(image_scale);
   assign pix      = sprod[70:32];

   always_comb begin
      if (!is_br) begin
         if (neg_ff) val = 14'd0;
         else val = (pix > 39'd8191) ? 14'd8191 : 14'(pix);
      end else if (gpos_big_ff) begin
         val = (!lim[14] && lim[13]) ? 14'd8191 : 14'(lim);
      end else if (neg_ff) begin
         val = (pix > 39'd8192) ? 14'h2000 : 14'(-pix);
      end else begin
         val = (pix > 39'd8191) ? 14'd8191 : 14'(pix);
      end
   end

   assign in_pop = (st_ff == ST_IDLE) && in_valid;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (in_valid) st_in = ST_GRID;
         ST_GRID:  st_in = ST_IMAGE;
         ST_IMAGE: st_in = (idx_ff == 2'd3) ? ST_DONE : ST_GRID;
         ST_DONE:  if (!ovalid_ff || out_ready) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_IMAGE) idx_ff <= idx_ff + 1'b1;
         if (st_ff == ST_DONE && (!ovalid_ff || out_ready)) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) pk_ff <= peak;
      if (st_ff == ST_GRID) begin
         gmag_ff     <= gprod;
         neg_ff      <= corner[COORD_W-1] && cmag != 32'd0 && ratio != 24'd0;
         gpos_big_ff <= gpos_big;
      end
      if (st_ff == ST_IMAGE) res_ff[idx_ff] <= val;
      if (st_ff == ST_DONE && (!ovalid_ff || out_ready)) begin
         top_left_x     <= res_ff[0][12:0];
         top_left_y     <= res_ff[1][12:0];
         bottom_right_x <= res_ff[2];
         bottom_right_y <= res_ff[3];
         peak_score     <= pk_ff.score;
         quality_out    <= pk_ff.quality;
         quality_valid  <= pk_ff.quality_valid;
         label          <= pk_ff.label;
      end
   end

   assign out_valid = ovalid_ff;

endmodule

FILE: hw/rtl/center_heatmap_box_decode_unit.sv
`timescale 1ns / 1ps
// center heatmap box decoder top level; depends on chbd_pkg, chbd_front, chbd_queue, chbd_back
// a request is taken every cycle while the 4-deep peak queue has room
// non-peak cells do not enter the queue; the back end takes a peak only when idle and
// scales its corners in turn: ratio multiply in the grid state, image scale in the image state
// a peak passes the queue, then the idle, grid, image and done states, to the output register
// reset is synchronous: counters, queue and output valid clear, CSR registers take defaults

module center_heatmap_box_decode_unit
   import chbd_pkg::*;
#(
   parameter int GRID_W      = 128,
   parameter int GRID_H      = 128,
   parameter int NUM_CLASSES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // heat_score, pooled_max, box_width, box_height, offset_x, offset_y, quality_score
   input  logic [135:0]          req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // top_left_x, top_left_y, bottom_right_x, bottom_right_y, peak_score,
   // quality_out, label
   output logic [95:0]           rsp_tdata,
   // quality_valid
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [15:0] threshold_ff;
   logic [23:0] ratio_w_ff, ratio_h_ff, image_scale_ff;
   logic [13:0] image_width_ff, image_height_ff;
   logic        quality_mode_ff;
   logic [31:0] class_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= 16'd19661;
         ratio_w_ff      <= 24'd262144;
         ratio_h_ff      <= 24'd262144;
         image_scale_ff  <= 24'd65536;
         image_width_ff  <= 14'd512;
         image_height_ff <= 14'd512;
         quality_mode_ff <= 1'b0;
         class_map_ff    <= 32'h76543210;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_THRESHOLD:    threshold_ff    <= csr_data[15:0];
            CSR_RATIO_W:      ratio_w_ff      <= csr_data[23:0];
            CSR_RATIO_H:      ratio_h_ff      <= csr_data[23:0];
            CSR_IMAGE_SCALE:  image_scale_ff  <= csr_data[23:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[13:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[13:0];
            CSR_QUALITY_MODE: quality_mode_ff <= csr_data[0];
            CSR_CLASS_MAP:    class_map_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   logic     push, full, q_valid, q_pop;
   peak_type push_data, pop_data;
   logic [12:0] tlx, tly;
   logic signed [13:0] brx, bry;
   logic [15:0] pscore, qout;
   logic [3:0]  lbl;

   chbd_front #(
      .GRID_W(GRID_W), .GRID_H(GRID_H), .NUM_CLASSES(NUM_CLASSES)
   ) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .heat_score(req_tdata[15:0]), .pooled_max(req_tdata[31:16]),
      .box_width(req_tdata[52:32]), .box_height(req_tdata[73:53]),
      .offset_x(req_tdata[94:74]), .offset_y(req_tdata[115:95]),
      .quality_score(req_tdata[132:116]), .last_in_image(req_tlast),
      .threshold(threshold_ff), .quality_mode(quality_mode_ff),
      .class_map(class_map_ff),
      .push, .peak(push_data), .full
   );

   chbd_queue u_queue (
      .clock, .reset, .push, .push_data, .full,
      .pop_valid(q_valid), .pop(q_pop), .pop_data
   );

   chbd_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_pop(q_pop), .peak(pop_data),
      .ratio_w(ratio_w_ff), .ratio_h(ratio_h_ff), .image_scale(image_scale_ff),
      .image_width(image_width_ff), .image_height(image_height_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .top_left_x(tlx), .top_left_y(tly), .bottom_right_x(brx), .bottom_right_y(bry),
      .peak_score(pscore), .quality_out(qout), .quality_valid(rsp_tuser), .label(lbl)
   );

   assign rsp_tdata = {6'd0, lbl, qout, pscore, bry, brx, tly, tlx};

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_tready == !full) else $error("ready out of step with queue");

endmodule
